// File: hw/rtl/pfae_pkg.sv
// ----------------------------------------------------------------------------
// pfae_pkg
// Shared types and constants of the paged frame admission engine.
// ----------------------------------------------------------------------------
package pfae_pkg;

	localparam int unsigned KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		EV_ARRIVED = 3'd0,
		EV_FREED   = 3'd1,
		EV_ADMIT   = 3'd2,
		EV_TICK    = 3'd3,
		EV_DROP    = 3'd4
	} ev_kind_t;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [31:0] MEM_RESET  = 32'd2000;
	localparam logic [31:0] PAGE_RESET = 32'd100;

	typedef struct packed {
		logic        op;
		logic [15:0] job_id;
		logic [15:0] job_lifetime;
		logic [15:0] job_memory;
	} job_item_t;

	typedef struct packed {
		ev_kind_t    event_kind;
		logic [15:0] event_job;
		logic [31:0] event_time;
		logic [4:0]  event_frame;
		logic [31:0] finish_time;
		logic        last_of_run;
	} event_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic arrive;
		logic free_step;
		logic div_start;
		logic div_step;
		logic count_step;
		logic alloc_step;
		logic keep_job;
		logic next_job;
		logic tick_end;
		logic emit_drop;
		logic emit_arrive;
		logic emit_free;
		logic emit_admit;
		logic emit_tick;
		logic nf_start;
		logic nf_step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op;
		logic queue_full;
		logic free_hit;
		logic free_last;
		logic div_done;
		logic count_last;
		logic fits;
		logic alloc_last;
		logic jobs_left;
		logic nf_done;
		logic out_busy;
	} dp_sts_t;

endpackage

// File: hw/rtl/pfae_stream_if.sv
// ----------------------------------------------------------------------------
// pfae_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface pfae_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/pfae_ctrl.sv
// ----------------------------------------------------------------------------
// pfae_ctrl
// Sequencer: steps the datapath through arrival and tick processing.
// ----------------------------------------------------------------------------
module pfae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfae_pkg::dp_sts_t sts,
	output pfae_pkg::dp_cmd_t cmd
);
	import pfae_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_ARR_OUT, ST_FREE, ST_FREE_OUT, ST_NF, ST_JOB,
		ST_DIV, ST_COUNT, ST_DECIDE, ST_ALLOC, ST_ADMIT_OUT, ST_TICK_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.load_item = in_valid;
			ST_DECODE:    cmd.nf_start = sts.op;
			ST_ARR_OUT: begin
				if (!sts.out_busy) begin
					cmd.emit_drop = sts.queue_full;
					cmd.emit_arrive = !sts.queue_full;
					cmd.arrive = !sts.queue_full;
				end
			end
			ST_FREE: begin
				cmd.nf_step = 1'b1;
				cmd.free_step = !sts.free_hit;
			end
			ST_FREE_OUT: begin
				cmd.nf_step = 1'b1;
				if (!sts.out_busy) begin
					cmd.emit_free = 1'b1;
					cmd.free_step = 1'b1;
				end
			end
			ST_NF:        cmd.nf_step = 1'b1;
			ST_JOB:       cmd.div_start = sts.jobs_left;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_COUNT:     cmd.count_step = 1'b1;
			ST_DECIDE: begin
				cmd.keep_job = !sts.fits;
				cmd.next_job = !sts.fits;
			end
			ST_ALLOC:     cmd.alloc_step = 1'b1;
			ST_ADMIT_OUT: begin
				if (!sts.out_busy) begin
					cmd.emit_admit = 1'b1;
					cmd.next_job = 1'b1;
				end
			end
			ST_TICK_OUT: begin
				if (!sts.out_busy) begin
					cmd.emit_tick = 1'b1;
					cmd.tick_end = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_DECODE;
				ST_DECODE: state_q <= sts.op ? ST_FREE : ST_ARR_OUT;
				ST_ARR_OUT: if (!sts.out_busy) state_q <= ST_IDLE;
				ST_FREE: begin
					if (sts.free_hit) state_q <= ST_FREE_OUT;
					else if (sts.free_last) state_q <= ST_NF;
				end
				ST_FREE_OUT: begin
					if (!sts.out_busy) state_q <= sts.free_last ? ST_NF : ST_FREE;
				end
				ST_NF:     if (sts.nf_done) state_q <= ST_JOB;
				ST_JOB:    state_q <= sts.jobs_left ? ST_DIV : ST_TICK_OUT;
				ST_DIV:    if (sts.div_done) state_q <= ST_COUNT;
				ST_COUNT:  if (sts.count_last) state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= sts.fits ? ST_ALLOC : ST_JOB;
				ST_ALLOC:  if (sts.alloc_last) state_q <= ST_ADMIT_OUT;
				ST_ADMIT_OUT: if (!sts.out_busy) state_q <= ST_JOB;
				ST_TICK_OUT:  if (!sts.out_busy) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/pfae_dp.sv
// ----------------------------------------------------------------------------
// pfae_dp
// Datapath: frame table, wait queue, tick clock, serial divider and the
// output register.
// ----------------------------------------------------------------------------
module pfae_dp #(
	parameter int FRAME_SLOTS = 32,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfae_pkg::job_item_t   item,
	input  logic [15:0]           memory_bytes,
	input  logic [12:0]           page_bytes,
	input  pfae_pkg::dp_cmd_t     cmd,
	output pfae_pkg::dp_sts_t     sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pfae_pkg::event_item_t out_item
);
	import pfae_pkg::*;

	localparam int FW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(FRAME_SLOTS + 1);

	job_item_t   item_q;
	logic [FRAME_SLOTS-1:0] busy_q;
	logic [15:0] owner_q [FRAME_SLOTS];
	logic [31:0] fend_q [FRAME_SLOTS];
	logic [15:0] wid_q [QUEUE_DEPTH];
	logic [15:0] wlife_q [QUEUE_DEPTH];
	logic [15:0] wmem_q [QUEUE_DEPTH];
	logic [CW-1:0] wcount_q, rd_q, keep_q;
	logic [31:0] clock_q;
	logic [FW-1:0] fidx_q;
	logic [NW-1:0] freec_q, need_q, took_q, nf_q;
	logic        big_q;
	logic [16:0] num_q;
	logic [16:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  bit_q;
	logic [12:0] pg;
	logic [31:0] fin;
	logic [QW-1:0] rd_idx;
	logic        emit_any;

	assign pg = (page_bytes == '0) ? 13'd1 : page_bytes;
	assign rd_idx = rd_q[QW-1:0];
	assign fin = clock_q + {16'd0, wlife_q[rd_idx]};
	assign emit_any = cmd.emit_drop || cmd.emit_arrive || cmd.emit_free ||
		cmd.emit_admit || cmd.emit_tick;

	logic [17:0] trial;
	assign trial = {rem_q, num_q[16]} - {5'd0, pg};

	logic in_range;
	assign in_range = ({{(32-FW){1'b0}}, fidx_q} < {{(32-NW){1'b0}}, nf_q});

	assign sts.op         = item_q.op;
	assign sts.queue_full = (wcount_q >= CW'(QUEUE_DEPTH));
	assign sts.free_hit   = busy_q[fidx_q] && (fend_q[fidx_q] <= clock_q);
	assign sts.free_last  = (fidx_q == FW'(FRAME_SLOTS - 1));
	assign sts.div_done   = (bit_q == 5'd0);
	assign sts.count_last = (fidx_q == FW'(FRAME_SLOTS - 1));
	// a need beyond the table can never be met
	assign sts.fits       = !big_q && (freec_q >= need_q);
	assign sts.alloc_last = (took_q >= need_q) || (fidx_q == FW'(FRAME_SLOTS - 1));
	assign sts.jobs_left  = (rd_q < wcount_q);
	assign sts.nf_done    = sts.div_done;
	assign sts.out_busy   = out_valid && !out_ready;

	// frame count and need share one restoring divider, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		if (cmd.nf_start || cmd.div_start) begin
			num_q <= cmd.nf_start ? {1'b0, memory_bytes}
				: {1'b0, wmem_q[rd_idx]} + {4'd0, pg} - 17'd1;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= 5'd17;
		end else if ((cmd.nf_step || cmd.div_step) && bit_q != 5'd0) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], num_q[16]};
				quo_q <= {quo_q[15:0], 1'b0};
			end
			num_q <= {num_q[15:0], 1'b0};
			bit_q <= bit_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			wcount_q <= '0;
			clock_q  <= '0;
			fidx_q   <= '0;
			rd_q     <= '0;
			keep_q   <= '0;
			freec_q  <= '0;
			need_q   <= '0;
			took_q   <= '0;
			nf_q     <= '0;
			big_q    <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				owner_q[i] <= '0;
				fend_q[i]  <= '0;
			end
		end else begin
			if (emit_any) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.load_item) begin
				fidx_q <= '0;
				rd_q   <= '0;
				keep_q <= '0;
			end
			if (cmd.arrive) begin
				wid_q[wcount_q[QW-1:0]]   <= item_q.job_id;
				wlife_q[wcount_q[QW-1:0]] <= item_q.job_lifetime;
				wmem_q[wcount_q[QW-1:0]]  <= item_q.job_memory;
				wcount_q <= wcount_q + 1'b1;
			end
			if (cmd.free_step) begin
				if (cmd.emit_free) begin
					busy_q[fidx_q]  <= 1'b0;
					owner_q[fidx_q] <= '0;
					fend_q[fidx_q]  <= '0;
				end
				fidx_q <= sts.free_last ? '0 : fidx_q + 1'b1;
			end
			if (cmd.nf_step && sts.div_done) begin
				nf_q <= (quo_q > 17'(FRAME_SLOTS)) ? NW'(FRAME_SLOTS) : quo_q[NW-1:0];
			end
			if (cmd.div_start) begin
				fidx_q  <= '0;
				freec_q <= '0;
				took_q  <= '0;
			end
			if (cmd.div_step && sts.div_done) begin
				need_q <= (quo_q > 17'(FRAME_SLOTS)) ? NW'(FRAME_SLOTS) : quo_q[NW-1:0];
				big_q  <= (quo_q > 17'(FRAME_SLOTS));
			end
			if (cmd.count_step) begin
				if (in_range && !busy_q[fidx_q]) freec_q <= freec_q + 1'b1;
				fidx_q <= sts.count_last ? '0 : fidx_q + 1'b1;
			end
			if (cmd.alloc_step) begin
				if (in_range && !busy_q[fidx_q] && took_q < need_q) begin
					busy_q[fidx_q]  <= 1'b1;
					owner_q[fidx_q] <= wid_q[rd_idx];
					fend_q[fidx_q]  <= fin;
					took_q <= took_q + 1'b1;
				end
				fidx_q <= fidx_q + 1'b1;
			end
			if (cmd.keep_job) begin
				wid_q[keep_q[QW-1:0]]   <= wid_q[rd_idx];
				wlife_q[keep_q[QW-1:0]] <= wlife_q[rd_idx];
				wmem_q[keep_q[QW-1:0]]  <= wmem_q[rd_idx];
				keep_q <= keep_q + 1'b1;
			end
			if (cmd.next_job) rd_q <= rd_q + 1'b1;
			if (cmd.tick_end) begin
				wcount_q <= keep_q;
				clock_q  <= clock_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			out_item.event_time  <= clock_q;
			out_item.event_frame <= '0;
			out_item.finish_time <= '0;
			out_item.last_of_run <= cmd.emit_drop || cmd.emit_arrive || cmd.emit_tick;
			out_item.event_job   <= item_q.job_id;
			priority if (cmd.emit_drop) begin
				out_item.event_kind <= EV_DROP;
			end else if (cmd.emit_arrive) begin
				out_item.event_kind <= EV_ARRIVED;
			end else if (cmd.emit_free) begin
				out_item.event_kind  <= EV_FREED;
				out_item.event_job   <= owner_q[fidx_q];
				out_item.event_frame <= 5'(fidx_q);
			end else if (cmd.emit_admit) begin
				out_item.event_kind  <= EV_ADMIT;
				out_item.event_job   <= wid_q[rd_idx];
				out_item.finish_time <= fin;
			end else begin
				out_item.event_kind <= EV_TICK;
				out_item.event_job  <= '0;
			end
		end
	end
endmodule

// File: hw/rtl/paged_frame_admission_engine_unit.sv
// ----------------------------------------------------------------------------
// paged_frame_admission_engine_unit
// Frame allocator with a wait queue scanned in arrival order, driven by arrival and tick items.
// ----------------------------------------------------------------------------
// One item at a time. An arrival is decoded and then emits its event, which
// an output stall can hold. A tick sweeps the whole frame table to release
// expired frames, with an event per freed frame, while the frame count
// divide runs under the sweep. Then, per waiting job, the serial divider
// works out the page need, a sweep counts free frames and a decision step
// follows; an admitted job also gets an allocation sweep and its event.
// A tick event closes the tick. The frame table sweeps and the bit-serial
// divider dominate the time. Every event leaves through an output register.
module paged_frame_admission_engine_unit #(
	parameter int FRAME_SLOTS = 32,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pfae_stream_if.sink   in_ch,
	pfae_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pfae_pkg::*;

	localparam logic [2:0] ADDR_MEM  = 3'd0;
	localparam logic [2:0] ADDR_PAGE = 3'd4;

	logic [15:0] memory_bytes_q;
	logic [12:0] page_bytes_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic in_ready;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_bytes_q <= MEM_RESET[15:0];
			page_bytes_q   <= PAGE_RESET[12:0];
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_MEM) memory_bytes_q <= pwdata[15:0];
			if (paddr == ADDR_PAGE) page_bytes_q <= pwdata[12:0];
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_MEM:  prdata = {16'd0, memory_bytes_q};
			ADDR_PAGE: prdata = {19'd0, page_bytes_q};
			default:   prdata = '0;
		endcase
	end

	assign in_ch.ready = in_ready;

	pfae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfae_dp #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (in_ch.payload),
		.memory_bytes (memory_bytes_q),
		.page_bytes   (page_bytes_q),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_item     (out_ch.payload)
	);
endmodule
